### rtl/fcd_pkg.sv
// Shared types and constants for the fixed-capacity deque.
// Used by the top level and the port checker; no dependencies.
package fcd_pkg;

   typedef logic [2:0] cmd_type;
   typedef logic [1:0] status_type;
   typedef logic signed [31:0] word_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_REAR  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_REAR   = 3'd3;
   localparam cmd_type CMD_SEARCH     = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam int REQ_W = 40;
   localparam int RSP_W = 48;

   // rsp_tdata bit positions
   localparam int RSP_FOUND_LSB  = 32;
   localparam int RSP_POS_LSB    = 33;
   localparam int RSP_STATUS_LSB = 37;
   localparam int RSP_COUNT_LSB  = 39;

endpackage

### rtl/fixed_capacity_deque.sv
// Fixed-capacity deque of signed 32-bit words, top level.
// Depends on fcd_pkg; the port checker in fcd_checker.sv binds to it.
//
// Holds up to DEPTH words in a circular single-port-read memory. One request
// is worked at a time and req_tready is low while it is in flight. A search
// reads the live entries through the one memory read port, one per cycle,
// and a single comparator checks each against the key.
// The finished response sits in an output register, so the next request is
// accepted while the previous response still waits for rsp_tready.
module fixed_capacity_deque #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [2:0] cmd, [34:3] value, [39:35] zero
   input  logic [fcd_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] data, [32] found, [36:33] position, [38:37] status,
   // [43:39] count, [47:44] zero
   output logic [fcd_pkg::RSP_W-1:0]   rsp_tdata
);
   import fcd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   occ_ff, occ_in;
   logic [AW-1:0]   slot_ff, slot_in;
   logic [CW-1:0]   left_ff, left_in;
   logic [AW-1:0]   issue_idx_ff, issue_idx_in;
   logic [AW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic            cmp_valid_ff, cmp_valid_in;
   cmd_type         cmd_ff, cmd_in;
   word_type        key_ff, key_in;
   logic            found_ff, found_in;
   logic [AW-1:0]   pos_ff, pos_in;
   status_type      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   word_type        entries_ff [DEPTH];
   word_type        rd_data_ff;
   logic            rd_en;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;

   logic            req_xfer;
   cmd_type         req_cmd;
   word_type        req_value;
   logic            full, empty;
   logic [AW-1:0]   head_dec, head_inc, slot_inc, rear_slot, last_slot;
   logic [SW-1:0]   rear_sum, last_sum;
   logic            is_pop, match;
   logic [31:0]     pos_ext, count_ext;
   word_type        out_data;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign req_cmd    = req_tdata[2:0];
   assign req_value  = req_tdata[34:3];

   assign full  = (occ_ff == CW'(DEPTH));
   assign empty = (occ_ff == '0);

   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign slot_inc = (slot_ff == AW'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   assign rear_sum  = SW'(head_ff) + SW'(occ_ff);
   assign rear_slot = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);
   assign last_sum  = rear_sum - 1'b1;
   assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

   assign is_pop = (cmd_ff == CMD_POP_FRONT) || (cmd_ff == CMD_POP_REAR);
   assign match  = cmp_valid_ff && (cmd_ff == CMD_SEARCH) && (rd_data_ff == key_ff);
   assign rd_en  = (state_ff == S_SCAN) && (left_ff != '0);

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= key_in;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[slot_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      issue_idx_in = issue_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = head_dec;
      pos_ext      = 32'(pos_ff);
      count_ext    = 32'(occ_ff);
      out_data     = (is_pop && status_ff == ST_OK) ? rd_data_ff : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in       = req_cmd;
               key_in       = req_value;
               found_in     = 1'b0;
               pos_in       = '0;
               status_in    = ST_OK;
               issue_idx_in = '0;
               state_in     = S_DONE;
               unique case (req_cmd)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        head_in = head_dec;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_REAR: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = rear_slot;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        slot_in  = head_ff;
                        left_in  = CW'(1);
                        head_in  = head_inc;
                        occ_in   = occ_ff - 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_POP_REAR: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        slot_in  = last_slot;
                        left_in  = CW'(1);
                        occ_in   = occ_ff - 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_SEARCH: begin
                     slot_in  = head_ff;
                     left_in  = occ_ff;
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (left_ff != '0) begin
               slot_in      = slot_inc;
               left_in      = left_ff - 1'b1;
               cmp_idx_in   = issue_idx_ff;
               issue_idx_in = issue_idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = S_DONE;
            end
            if (match) begin
               found_in = 1'b1;
               pos_in   = cmp_idx_ff;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, count_ext[4:0], status_ff, pos_ext[3:0],
                               found_ff, out_data};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      left_ff      <= left_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/fcd_checker.sv
// Port-level checks for the fixed-capacity deque, bound to the top level.
// Depends on fcd_pkg and fixed_capacity_deque.
module fcd_checker #(
   parameter int DEPTH = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [fcd_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [fcd_pkg::RSP_W-1:0] rsp_tdata
);
   import fcd_pkg::*;

   status_type rsp_status;
   logic [4:0] rsp_count;
   logic       rsp_found;
   logic       req_seen;

   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: 2];
   assign rsp_count  = rsp_tdata[RSP_COUNT_LSB +: 5];
   assign rsp_found  = rsp_tdata[RSP_FOUND_LSB];
   assign req_seen   = req_tvalid & (req_tdata != '0 || req_tdata == '0);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_seen && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status == ST_OK || rsp_status == ST_EMPTY ||
                     rsp_status == ST_FULL)
      else $error("reserved status code");

   // a hit comes only from a search, which returns no data
   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_found |-> rsp_status == ST_OK && rsp_tdata[31:0] == '0)
      else $error("found set with bad status or data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_FULL |-> rsp_count == 5'(DEPTH))
      else $error("full reported below capacity");

endmodule

bind fixed_capacity_deque fcd_checker #(.DEPTH(DEPTH)) u_fcd_checker (.*);

### test/fixed_capacity_deque_test.sv
// Self-checking testbench for fixed_capacity_deque: directed and random deque traffic,
// random input bursts and output stalls, results checked against an in-bench deque model.
// Depends on fcd_pkg and rtl/fixed_capacity_deque.sv.
`timescale 1ns / 1ps

module fixed_capacity_deque_test;
   import fcd_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_ITEMS = 1300;
   localparam cmd_type CMD_RESERVED_HI = 3'd7;

   typedef struct packed {
      cmd_type  cmd;
      word_type value;
   } deque_request_type;

   typedef struct packed {
      word_type   data;
      logic       found;
      logic [3:0] position;
      status_type status;
      logic [4:0] count;
   } deque_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   deque_request_type pending[$];
   deque_result_type  expected[$];
   int                mismatches = 0;

   // deque model state
   word_type model_slots[DEPTH];
   int       model_front = 0;
   int       model_fill = 0;

   word_type key_pool[6];

   fixed_capacity_deque #(.DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic deque_result_type apply_request(cmd_type cmd, word_type value);
      deque_result_type r;
      int i;
      r = '0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (model_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_front = (model_front + DEPTH - 1) % DEPTH;
               model_slots[model_front] = value;
               model_fill++;
            end
         end
         CMD_PUSH_REAR: begin
            if (model_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_slots[(model_front + model_fill) % DEPTH] = value;
               model_fill++;
            end
         end
         CMD_POP_FRONT: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = model_slots[model_front];
               model_front = (model_front + 1) % DEPTH;
               model_fill--;
            end
         end
         CMD_POP_REAR: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = model_slots[(model_front + model_fill - 1) % DEPTH];
               model_fill--;
            end
         end
         CMD_SEARCH: begin
            for (i = 0; i < model_fill; i++) begin
               if (model_slots[(model_front + i) % DEPTH] == value) begin
                  r.found = 1'b1;
                  r.position = i[3:0];
               end
            end
         end
         default: ;
      endcase
      r.count = model_fill[4:0];
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_request(cmd_type cmd, word_type value);
      deque_request_type item;
      item.cmd = cmd;
      item.value = value;
      pending.push_back(item);
   endtask

   function automatic word_type pick_word();
      if ($urandom_range(0, 99) < 45)
         return key_pool[$urandom_range(0, 5)];
      return word_type'($urandom);
   endfunction

   // sender: bursts of random length separated by random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : req_driver
      deque_request_type item;
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready)
            expected.push_back(apply_request(req_tdata[2:0], req_tdata[34:3]));
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() != 0) begin
               item = pending.pop_front();
               offer = 1'b1;
               req_tdata <= {5'b0, item.value, item.cmd};
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
            req_tvalid <= offer;
         end
      end
   end

   // receiver: stall pattern switches among random modes; one long hold-off
   int drained = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin : rsp_stall
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            drained++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && drained >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      deque_result_type want;
      word_type    got_data;
      logic        got_found;
      logic [3:0]  got_pos;
      status_type  got_status;
      logic [4:0]  got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_data   = rsp_tdata[31:0];
         got_found  = rsp_tdata[RSP_FOUND_LSB];
         got_pos    = rsp_tdata[RSP_POS_LSB +: 4];
         got_status = rsp_tdata[RSP_STATUS_LSB +: 2];
         got_count  = rsp_tdata[RSP_COUNT_LSB +: 5];
         if (expected.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, tdata %h", rsp_tdata));
         end else begin
            want = expected.pop_front();
            if (got_data !== want.data)
               report_mismatch($sformatf("data %0d, expected %0d", got_data, want.data));
            if (got_found !== want.found)
               report_mismatch($sformatf("found %b, expected %b", got_found, want.found));
            if (got_pos !== want.position)
               report_mismatch($sformatf("position %0d, expected %0d", got_pos,
                                         want.position));
            if (got_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", got_status,
                                         want.status));
            if (got_count !== want.count)
               report_mismatch($sformatf("count %0d, expected %0d", got_count, want.count));
         end
      end
   end

   initial begin : stimulus
      int  n;
      int  phase_left;
      bit  grow;
      int  pick;
      int  total;
      cmd_type cmd;

      key_pool[0] = 32'sd0;
      key_pool[1] = -32'sd1;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7fff_ffff;
      key_pool[4] = word_type'($urandom);
      key_pool[5] = word_type'($urandom);

      // empty deque corner cases
      queue_request(CMD_POP_FRONT, 32'sd5);
      queue_request(CMD_POP_REAR, -32'sd5);
      queue_request(CMD_SEARCH, 32'sd0);
      queue_request(CMD_RESERVED_HI, 32'hffff_ffff);
      // extremes at both ends, front push wraps the head
      queue_request(CMD_PUSH_FRONT, 32'h7fff_ffff);
      queue_request(CMD_PUSH_REAR, 32'h8000_0000);
      queue_request(CMD_PUSH_FRONT, -32'sd1);
      queue_request(CMD_PUSH_REAR, 32'sd0);
      queue_request(CMD_SEARCH, 32'h8000_0000);
      // fill with duplicates, then push onto a full deque
      for (n = 0; n < DEPTH - 4; n++)
         queue_request(CMD_PUSH_REAR, -32'sd1);
      queue_request(CMD_PUSH_FRONT, 32'sd1);
      queue_request(CMD_SEARCH, -32'sd1);
      queue_request(CMD_POP_REAR, 32'sd0);
      queue_request(CMD_POP_FRONT, 32'sd0);

      // random traffic, alternating fill and drain phases
      grow = 1'b1;
      phase_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            grow = ~grow;
            phase_left = $urandom_range(10, 60);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            cmd = cmd_type'(CMD_SEARCH + $urandom_range(1, 3));
            queue_request(cmd, word_type'($urandom));
         end else if (pick < 23) begin
            queue_request(CMD_SEARCH, pick_word());
         end else if ($urandom_range(0, 99) < (grow ? 75 : 25)) begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
            queue_request(cmd, pick_word());
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
            queue_request(cmd, word_type'($urandom));
         end
      end
      total = pending.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every transfer in must come back out
      while (drained < total)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
